// File: sv/cbs_pkg.sv
package cbs_pkg;

   localparam int POINT_W     = 18;
   localparam int POINT_FRAC  = 12;
   localparam int OUT_W       = 17;
   localparam int OUT_FRAC    = 16;
   localparam int ORDER_W     = 4;
   localparam int MAX_ORDER   = 8;
   localparam int ORDER_RESET = 4;
   localparam int EXP_W       = 3;
   localparam int IDX_W       = 4;

   localparam int ADDR_W      = 2;
   localparam int DATA_W      = 32;
   localparam logic [ADDR_W-1:0] CSR_ORDER_ADDR = '0;

   // Term arithmetic: 32-bit limbs times a 16-bit operand per cycle
   localparam int LIMB_W      = 32;
   localparam int LIMBS       = 4;
   localparam int LIMB_IDX_W  = $clog2(LIMBS);
   localparam int ACC_W       = LIMB_W * LIMBS;
   localparam int BASE_W      = 16;
   localparam int PROD_W      = LIMB_W + BASE_W;
   localparam int SHIFT_W     = 7;
   localparam int SCALED_W    = ACC_W + OUT_FRAC;

   // Final scaling: factorial divisor and quotient below 2^17
   localparam int COMB_W      = 7;
   localparam int FCT_W       = 13;
   localparam int QUOT_W      = 17;
   localparam int DIVD_W      = FCT_W + QUOT_W - 1;
   localparam int CNT_W       = 5;

   localparam logic [OUT_W-1:0] FULL_SCALE = OUT_W'(1 << OUT_FRAC);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TERM,
      ST_MUL,
      ST_ACC,
      ST_SCALE,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef logic [COMB_W-1:0] binom_row_type [0:MAX_ORDER];

   localparam binom_row_type BINOM [0:MAX_ORDER] = '{
      '{7'd1, 7'd0, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0, 7'd0},
      '{7'd1, 7'd1, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0, 7'd0},
      '{7'd1, 7'd2, 7'd1,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0, 7'd0},
      '{7'd1, 7'd3, 7'd3,  7'd1,  7'd0,  7'd0,  7'd0,  7'd0, 7'd0},
      '{7'd1, 7'd4, 7'd6,  7'd4,  7'd1,  7'd0,  7'd0,  7'd0, 7'd0},
      '{7'd1, 7'd5, 7'd10, 7'd10, 7'd5,  7'd1,  7'd0,  7'd0, 7'd0},
      '{7'd1, 7'd6, 7'd15, 7'd20, 7'd15, 7'd6,  7'd1,  7'd0, 7'd0},
      '{7'd1, 7'd7, 7'd21, 7'd35, 7'd35, 7'd21, 7'd7,  7'd1, 7'd0},
      '{7'd1, 7'd8, 7'd28, 7'd56, 7'd70, 7'd56, 7'd28, 7'd8, 7'd1}
   };

   function automatic logic [COMB_W-1:0] binom(input logic [IDX_W-1:0] n,
                                                input logic [IDX_W-1:0] k);
      logic [COMB_W-1:0] c;
      c = '0;
      if (n <= IDX_W'(MAX_ORDER) && k <= IDX_W'(MAX_ORDER)) begin
         c = BINOM[n][k];
      end
      return c;
   endfunction

   function automatic logic [FCT_W-1:0] fact(input logic [EXP_W-1:0] e);
      logic [FCT_W-1:0] f;
      unique case (e)
         3'd0:    f = 13'd1;
         3'd1:    f = 13'd1;
         3'd2:    f = 13'd2;
         3'd3:    f = 13'd6;
         3'd4:    f = 13'd24;
         3'd5:    f = 13'd120;
         3'd6:    f = 13'd720;
         3'd7:    f = 13'd5040;
         default: f = 13'd1;
      endcase
      return f;
   endfunction

endpackage

// File: sv/cbs_div.sv
module cbs_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [cbs_pkg::DIVD_W-1:0]   dividend,
   input  logic [cbs_pkg::FCT_W-1:0]    divisor,
   output logic                         done,
   output logic [cbs_pkg::QUOT_W-1:0]   quotient
);
   import cbs_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [FCT_W-1:0]    rem_ff, rem_in;
   logic [FCT_W-1:0]    div_ff, div_in;
   logic [QUOT_W-1:0]   shreg_ff, shreg_in;
   logic [FCT_W:0]      trial;
   logic                ge;

   // Caller guarantees the quotient fits in QUOT_W bits, so the top
   // dividend bits already sit below the divisor.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      shreg_in = shreg_ff;
      trial    = {rem_ff, shreg_ff[QUOT_W-1]};
      ge       = trial >= {1'b0, div_ff};
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         rem_in   = FCT_W'(dividend[DIVD_W-1:QUOT_W]);
         shreg_in = dividend[QUOT_W-1:0];
         div_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = ge ? FCT_W'(trial - {1'b0, div_ff}) : FCT_W'(trial);
         shreg_in = {shreg_ff[QUOT_W-2:0], ge};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(QUOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      shreg_ff <= shreg_in;
   end

   assign done     = done_ff;
   assign quotient = shreg_ff;

endmodule

// File: sv/cardinal_bspline_eval.sv
// Cardinal B-spline of order n (register order, 1..8; 0 acts as 1, above 8 as 8)
// at a signed Q5.12 point, returned as unsigned Q1.16 saturated to 1.0. Each
// request is summed exactly over the truncated powers (t-i)^(n-1) in a 128-bit
// accumulator, using one 32x16 limb multiplier: each term takes n multiplies of
// four limb passes each (n-1 powers plus the binomial weight), and floor(t)+1
// terms are formed, at most n+1. The sum is then scaled and divided by (n-1)!
// in a bit-serial divider. The block takes one request at a time; req_ready
// rises again as soon as the result moves to the output register.
module cardinal_bspline_eval (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [cbs_pkg::POINT_W-1:0] req_point,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [cbs_pkg::OUT_W-1:0]      rsp_spline_value,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [cbs_pkg::ADDR_W-1:0]     paddr,
   input  logic [cbs_pkg::DATA_W-1:0]     pwdata,
   output logic [cbs_pkg::DATA_W-1:0]     prdata,
   output logic                           pready
);
   import cbs_pkg::*;

   state_type                        state_ff, state_in;
   logic [ORDER_W-1:0]               order_ff;
   logic signed [POINT_W-1:0]        point_ff, point_in;
   logic [IDX_W-1:0]                 n_ff, n_in;
   logic [EXP_W-1:0]                 e_ff, e_in;
   logic [IDX_W-1:0]                 idx_ff, idx_in;
   logic [EXP_W-1:0]                 k_ff, k_in;
   logic [LIMB_IDX_W-1:0]            limb_ff, limb_in;
   logic [BASE_W-1:0]                carry_ff, carry_in;
   logic [LIMBS-1:0][LIMB_W-1:0]     term_ff, term_in;
   logic [ACC_W-1:0]                 acc_ff, acc_in;
   logic [BASE_W-1:0]                base_ff, base_in;
   logic [OUT_W-1:0]                 result_ff, result_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]                 rsp_value_ff, rsp_value_in;

   logic [IDX_W-1:0]                 n_clamp;
   logic signed [POINT_W-1:0]        upper;
   logic signed [POINT_W-1:0]        base_s;
   logic [BASE_W-1:0]                mul_op;
   logic [PROD_W-1:0]                prod;
   logic [FCT_W-1:0]                 fct;
   logic [SHIFT_W-1:0]               shift_amt;
   logic [SCALED_W-1:0]              scaled;
   logic [DIVD_W-1:0]                limit;
   logic                             sat;
   logic                             div_start;
   logic                             div_done;
   logic [QUOT_W-1:0]                div_quot;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_W'(ORDER_RESET);
      end else if (psel && penable && pwrite && pready) begin
         order_ff <= pwdata[ORDER_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == CSR_ORDER_ADDR) ? DATA_W'(order_ff) : '0;

   always_comb begin
      priority if (order_ff == '0) begin
         n_clamp = IDX_W'(1);
      end else if (order_ff > ORDER_W'(MAX_ORDER)) begin
         n_clamp = IDX_W'(MAX_ORDER);
      end else begin
         n_clamp = IDX_W'(order_ff);
      end
   end

   assign upper  = $signed({2'b00, n_clamp, {POINT_FRAC{1'b0}}});
   assign base_s = point_ff - $signed({2'b00, idx_ff, {POINT_FRAC{1'b0}}});

   // Shared limb multiplier: last pass of a term applies the binomial weight
   assign mul_op = ({1'b0, k_ff} == {1'b0, e_ff}) ? BASE_W'(binom(n_ff, idx_ff)) : base_ff;
   assign prod   = PROD_W'(term_ff[limb_ff]) * PROD_W'(mul_op) + PROD_W'(carry_ff);

   // Scale by 2^16 / 2^(12e), then saturate against 65537 * (n-1)!
   assign fct       = fact(e_ff);
   assign shift_amt = SHIFT_W'(e_ff) * SHIFT_W'(POINT_FRAC);
   assign scaled    = {acc_ff, {OUT_FRAC{1'b0}}} >> shift_amt;
   assign limit     = DIVD_W'({fct, {OUT_FRAC{1'b0}}}) + DIVD_W'(fct);
   assign sat       = (|scaled[SCALED_W-1:DIVD_W]) || (scaled[DIVD_W-1:0] >= limit);

   always_comb begin
      state_in     = state_ff;
      point_in     = point_ff;
      n_in         = n_ff;
      e_in         = e_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      limb_in      = limb_ff;
      carry_in     = carry_ff;
      term_in      = term_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      div_start    = 1'b0;
      req_ready    = (state_ff == ST_IDLE);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               point_in = req_point;
               n_in     = n_clamp;
               e_in     = EXP_W'(n_clamp - 1'b1);
               idx_in   = '0;
               acc_in   = '0;
               if (req_point < 0 || req_point > upper) begin
                  result_in = '0;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_TERM;
               end
            end
         end
         ST_TERM: begin
            if (idx_ff > n_ff || base_s < 0) begin
               state_in = ST_SCALE;
            end else begin
               base_in  = base_s[BASE_W-1:0];
               term_in  = ACC_W'(1);
               k_in     = '0;
               limb_in  = '0;
               carry_in = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            term_in[limb_ff] = prod[LIMB_W-1:0];
            carry_in         = prod[PROD_W-1:LIMB_W];
            limb_in          = limb_ff + 1'b1;
            if (limb_ff == LIMB_IDX_W'(LIMBS - 1)) begin
               carry_in = '0;
               if (k_ff == e_ff) begin
                  state_in = ST_ACC;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         ST_ACC: begin
            acc_in   = idx_ff[0] ? acc_ff - term_ff : acc_ff + term_ff;
            idx_in   = idx_ff + 1'b1;
            state_in = ST_TERM;
         end
         ST_SCALE: begin
            if (sat) begin
               result_in = FULL_SCALE;
               state_in  = ST_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               result_in = div_quot;
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      point_ff     <= point_in;
      n_ff         <= n_in;
      e_ff         <= e_in;
      idx_ff       <= idx_in;
      k_ff         <= k_in;
      limb_ff      <= limb_in;
      carry_ff     <= carry_in;
      term_ff      <= term_in;
      acc_ff       <= acc_in;
      base_ff      <= base_in;
      result_ff    <= result_in;
      rsp_value_ff <= rsp_value_in;
   end

   cbs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (scaled[DIVD_W-1:0]),
      .divisor  (fct),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_spline_value = rsp_value_ff;

endmodule
